// ===== hdl/ghc_pkg.sv =====
// ----------------------------------------------------------------------------
// Gear hash chunker package
// Shared widths, register indexes, cut reason codes and the gear table.
// ----------------------------------------------------------------------------
package ghc_pkg;

  localparam int FP_BITS       = 64;
  localparam int LEN_BITS      = 21;
  localparam int OFFSET_BITS   = 48;
  localparam int OUT_OFF_BITS  = 48;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 64;

  localparam int MAX_CHUNK_LIMIT = 1048576;
  localparam logic [LEN_BITS-1:0] CHUNK_LIMIT = LEN_BITS'(MAX_CHUNK_LIMIT);

  localparam logic [FP_BITS-1:0]  RESET_MASK = FP_BITS'(64'd8191);
  localparam logic [LEN_BITS-1:0] RESET_MIN  = LEN_BITS'(2048);
  localparam logic [LEN_BITS-1:0] RESET_MAX  = LEN_BITS'(65536);

  localparam logic [63:0] GEAR_SEED = 64'h1234_5678_9abc_def0;

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] REG_BOUNDARY_MASK = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_MIN_CHUNK     = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_MAX_CHUNK     = 2'd2;

  typedef enum logic [1:0] {
    REASON_MATCH = 2'd0,
    REASON_MAX   = 2'd1,
    REASON_EOD   = 2'd2
  } cut_reason_t;

  typedef logic [FP_BITS-1:0] gear_rom_t [256];

  // Builds the gear table from a 64-bit xorshift sequence; evaluated at
  // elaboration only.
  function automatic gear_rom_t gen_gear_rom();
    gear_rom_t   rom;
    logic [63:0] v;
    v = GEAR_SEED;
    for (int i = 0; i < 256; i++) begin
      v = v ^ (v << 13);
      v = v ^ (v >> 7);
      v = v ^ (v << 17);
      rom[i] = v;
    end
    return rom;
  endfunction

  localparam gear_rom_t GEAR_ROM = gen_gear_rom();

endpackage

// ===== hdl/ghc_if.sv =====
// ----------------------------------------------------------------------------
// Gear hash chunker channel interfaces
// Valid/ready channels for input bytes, cut results and register writes.
// ----------------------------------------------------------------------------
interface ghc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_data;

  modport source (output valid, output data_byte, output end_of_data, input ready);
  modport sink (input valid, input data_byte, input end_of_data, output ready);
endinterface

interface ghc_out_if;
  logic                             valid;
  logic                             ready;
  logic [ghc_pkg::OUT_OFF_BITS-1:0] boundary_offset;
  logic [ghc_pkg::LEN_BITS-1:0]     chunk_length;
  logic [1:0]                       cut_reason;

  modport source (output valid, output boundary_offset, output chunk_length,
                  output cut_reason, input ready);
  modport sink (input valid, input boundary_offset, input chunk_length,
                input cut_reason, output ready);
endinterface

interface ghc_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [ghc_pkg::CFG_IDX_BITS-1:0]  index;
  logic [ghc_pkg::CFG_DATA_BITS-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hdl/gear_hash_chunk_boundary.sv =====
// ----------------------------------------------------------------------------
// Gear hash chunk boundary detector
// Content-defined chunking of a byte stream with a 64-bit gear fingerprint.
// ----------------------------------------------------------------------------
//   Channel   Dir  Carries
//   in_bus    in   data_byte, end_of_data
//   out_bus   out  boundary_offset, chunk_length, cut_reason
//   cfg_bus   in   index, data (register writes, always ready)
//
// One byte is taken every cycle unless the result register stalls; a byte's
// result is loaded into the result register when its input register advances.
// The gear table is read into the input register, and the fingerprint add, mask
// test and length compares sit before the result register.
// Reset restores the register defaults and clears fingerprint, length and offset.
// A stalled result register holds the input register, which then stalls in_bus.
// ----------------------------------------------------------------------------
module gear_hash_chunk_boundary (
  input  logic              clk,
  input  logic              rst_n,
  ghc_in_if.sink            in_bus,
  ghc_out_if.source         out_bus,
  ghc_cfg_if.sink           cfg_bus
);

  // Configuration registers.
  logic [ghc_pkg::FP_BITS-1:0]  mask_r;
  logic [ghc_pkg::LEN_BITS-1:0] min_r;
  logic [ghc_pkg::LEN_BITS-1:0] max_r;

  // Input register.
  logic                         in_valid_r;
  logic [ghc_pkg::FP_BITS-1:0]  gear_r;
  logic                         eod_r;

  // Chunking state.
  logic [ghc_pkg::FP_BITS-1:0]     fp_r, fp_nxt;
  logic [ghc_pkg::LEN_BITS-1:0]    count_r, count_nxt;
  logic [ghc_pkg::OFFSET_BITS-1:0] offset_r, offset_nxt;

  // Result register.
  logic                             out_valid_r, out_valid_nxt;
  logic [ghc_pkg::OUT_OFF_BITS-1:0] res_offset_r;
  logic [ghc_pkg::LEN_BITS-1:0]     res_length_r;
  ghc_pkg::cut_reason_t             res_reason_r;

  logic                            advance;
  logic [ghc_pkg::FP_BITS-1:0]     fp_sum;
  logic [ghc_pkg::LEN_BITS-1:0]    count_inc;
  logic [ghc_pkg::OFFSET_BITS-1:0] offset_inc;
  logic [ghc_pkg::LEN_BITS-1:0]    limit;
  logic                            match;
  logic                            at_max;
  logic                            cut;
  ghc_pkg::cut_reason_t            reason;

  assign advance      = in_valid_r && (!out_valid_r || out_bus.ready);
  assign in_bus.ready = !in_valid_r || advance;
  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= ghc_pkg::RESET_MASK;
      min_r  <= ghc_pkg::RESET_MIN;
      max_r  <= ghc_pkg::RESET_MAX;
    end else if (cfg_bus.valid) begin
      case (cfg_bus.index)
        ghc_pkg::REG_BOUNDARY_MASK: mask_r <= cfg_bus.data[ghc_pkg::FP_BITS-1:0];
        ghc_pkg::REG_MIN_CHUNK:     min_r  <= cfg_bus.data[ghc_pkg::LEN_BITS-1:0];
        ghc_pkg::REG_MAX_CHUNK:     max_r  <= cfg_bus.data[ghc_pkg::LEN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // The table lookup is done on transfer so the next stage sees only the add.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_bus.ready) begin
      in_valid_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.valid && in_bus.ready) begin
      gear_r <= ghc_pkg::GEAR_ROM[in_bus.data_byte];
      eod_r  <= in_bus.end_of_data;
    end
  end

  always_comb begin
    fp_sum     = (fp_r << 1) + gear_r;
    count_inc  = count_r + ghc_pkg::LEN_BITS'(1);
    offset_inc = offset_r + ghc_pkg::OFFSET_BITS'(1);
    limit      = (max_r > ghc_pkg::CHUNK_LIMIT) ? ghc_pkg::CHUNK_LIMIT : max_r;
    match      = (count_inc >= min_r) && ((fp_sum & mask_r) == '0);
    at_max     = (count_inc >= limit);
    cut        = match || at_max || eod_r;

    // A fingerprint match takes precedence over the size limit, and the size
    // limit over end of data.
    if (match) begin
      reason = ghc_pkg::REASON_MATCH;
    end else if (at_max) begin
      reason = ghc_pkg::REASON_MAX;
    end else begin
      reason = ghc_pkg::REASON_EOD;
    end

    fp_nxt     = fp_r;
    count_nxt  = count_r;
    offset_nxt = offset_r;
    if (advance) begin
      fp_nxt     = cut ? '0 : fp_sum;
      count_nxt  = cut ? '0 : count_inc;
      offset_nxt = eod_r ? '0 : offset_inc;
    end

    if (advance) begin
      out_valid_nxt = cut;
    end else if (out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fp_r        <= '0;
      count_r     <= '0;
      offset_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      fp_r        <= fp_nxt;
      count_r     <= count_nxt;
      offset_r    <= offset_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && cut) begin
      res_offset_r <= ghc_pkg::OUT_OFF_BITS'(offset_inc);
      res_length_r <= count_inc;
      res_reason_r <= reason;
    end
  end

  assign out_bus.valid           = out_valid_r;
  assign out_bus.boundary_offset = res_offset_r;
  assign out_bus.chunk_length    = res_length_r;
  assign out_bus.cut_reason      = res_reason_r;

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// Gear hash chunk boundary detector testbench
// Streams bytes into the chunker under several register settings and
// compares every cut against an independent fingerprint predictor.
// ----------------------------------------------------------------------------
module tb;

  // Index 3 maps to no register; writes there must leave everything alone.
  localparam logic [ghc_pkg::CFG_IDX_BITS-1:0] REG_UNUSED = 2'd3;
  localparam int     SETTLE_CYCLES = 8;
  localparam longint CYCLE_LIMIT   = 4_000_000;
  localparam int     RANDOM_BYTES  = 1300;

  typedef struct {
    logic [ghc_pkg::OUT_OFF_BITS-1:0] offset;
    logic [ghc_pkg::LEN_BITS-1:0]     length;
    ghc_pkg::cut_reason_t             reason;
  } chunk_cut_t;

  class chunk_sb;
    logic [ghc_pkg::FP_BITS-1:0]     gear [256];
    logic [ghc_pkg::FP_BITS-1:0]     mask;
    logic [ghc_pkg::LEN_BITS-1:0]    min_len;
    logic [ghc_pkg::LEN_BITS-1:0]    max_len;
    logic [ghc_pkg::FP_BITS-1:0]     fp;
    logic [ghc_pkg::LEN_BITS-1:0]    run_len;
    logic [ghc_pkg::OFFSET_BITS-1:0] stream_pos;
    chunk_cut_t                      expected_cuts [$];
    int                              errors;

    function new();
      logic [63:0] x;
      int          i;
      x = ghc_pkg::GEAR_SEED;
      for (i = 0; i < 256; i++) begin
        x ^= x << 13;
        x ^= x >> 7;
        x ^= x << 17;
        gear[i] = x;
      end
      mask       = ghc_pkg::RESET_MASK;
      min_len    = ghc_pkg::RESET_MIN;
      max_len    = ghc_pkg::RESET_MAX;
      fp         = '0;
      run_len    = '0;
      stream_pos = '0;
      errors     = 0;
    endfunction

    function void write_reg(logic [ghc_pkg::CFG_IDX_BITS-1:0] idx,
                            logic [ghc_pkg::CFG_DATA_BITS-1:0] d);
      case (idx)
        ghc_pkg::REG_BOUNDARY_MASK: mask = d;
        ghc_pkg::REG_MIN_CHUNK: min_len = d[ghc_pkg::LEN_BITS-1:0];
        ghc_pkg::REG_MAX_CHUNK: max_len = d[ghc_pkg::LEN_BITS-1:0];
        default: ;
      endcase
    endfunction

    // Advances the fingerprint by one byte and queues the cut it causes, if any.
    function void note_byte(logic [7:0] b, logic last);
      logic [ghc_pkg::LEN_BITS-1:0] limit;
      chunk_cut_t                   c;
      bit                           hit;
      limit = (max_len > ghc_pkg::CHUNK_LIMIT) ? ghc_pkg::CHUNK_LIMIT : max_len;
      fp = (fp << 1) + gear[b];
      run_len++;
      stream_pos++;
      hit = 1'b1;
      if (run_len >= min_len && (fp & mask) == '0) begin
        c.reason = ghc_pkg::REASON_MATCH;
      end else if (run_len >= limit) begin
        c.reason = ghc_pkg::REASON_MAX;
      end else if (last) begin
        c.reason = ghc_pkg::REASON_EOD;
      end else begin
        hit = 1'b0;
      end
      if (hit) begin
        c.offset = stream_pos[ghc_pkg::OUT_OFF_BITS-1:0];
        c.length = run_len;
        expected_cuts.push_back(c);
        fp      = '0;
        run_len = '0;
        // The last byte of a stream restarts the offset, whatever the reason.
        if (last) begin
          stream_pos = '0;
        end
      end
    endfunction

    function void check_cut(logic [ghc_pkg::OUT_OFF_BITS-1:0] off,
                            logic [ghc_pkg::LEN_BITS-1:0] len,
                            logic [1:0] why);
      chunk_cut_t c;
      if (expected_cuts.size() == 0) begin
        errors++;
        $display("%0t: unexpected cut, expected none, got offset %0d length %0d reason %0d",
                 $time, off, len, why);
        return;
      end
      c = expected_cuts.pop_front();
      if (off !== c.offset) begin
        errors++;
        $display("%0t: boundary_offset expected %0d, got %0d", $time, c.offset, off);
      end
      if (len !== c.length) begin
        errors++;
        $display("%0t: chunk_length expected %0d, got %0d", $time, c.length, len);
      end
      if (why !== c.reason) begin
        errors++;
        $display("%0t: cut_reason expected %0d, got %0d", $time, c.reason, why);
      end
    endfunction

    function int pending();
      return expected_cuts.size();
    endfunction
  endclass

  logic    clk;
  logic    rst_n;
  bit      in_calm;
  bit      out_calm;
  longint  cycles = 0;
  chunk_sb sb;

  ghc_in_if  in_bus ();
  ghc_out_if out_bus ();
  ghc_cfg_if cfg_bus ();

  gear_hash_chunk_boundary DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // Mostly back-to-back, sometimes a few cycles, rarely a long hold-off.
  function automatic int idle_len(bit calm);
    int r;
    if (calm) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 88) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [63:0] pick_mask();
    logic [63:0] m;
    int          n;
    case ($urandom_range(0, 5))
      0: m = '0;
      1: m = '1;
      2: m = {$urandom, $urandom};
      default: begin
        // A few set bits keep content cuts frequent.
        m = '0;
        n = $urandom_range(1, 4);
        repeat (n) m[$urandom_range(0, 63)] = 1'b1;
      end
    endcase
    return m;
  endfunction

  function automatic logic [63:0] pick_len(bit for_max);
    logic [63:0]                  d;
    logic [ghc_pkg::LEN_BITS-1:0] v;
    d = ($urandom_range(0, 1) == 1) ? {$urandom, $urandom} : '0;
    case ($urandom_range(0, 6))
      0: v = '0;
      1: v = ghc_pkg::LEN_BITS'($urandom_range(1, 8));
      2: v = ghc_pkg::LEN_BITS'($urandom_range(9, 64));
      3: v = ghc_pkg::LEN_BITS'($urandom_range(65, 300));
      4: v = ghc_pkg::CHUNK_LIMIT;
      5: v = '1;
      default: v = for_max ? ghc_pkg::CHUNK_LIMIT + ghc_pkg::LEN_BITS'(1)
                           : ghc_pkg::LEN_BITS'($urandom_range(1, 4));
    endcase
    d[ghc_pkg::LEN_BITS-1:0] = v;
    return d;
  endfunction

  task automatic send_byte(logic [7:0] b, logic last);
    int gap;
    gap = idle_len(in_calm);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid       <= 1'b1;
    in_bus.data_byte   <= b;
    in_bus.end_of_data <= last;
    do @(posedge clk); while (!in_bus.ready);
    sb.note_byte(b, last);
  endtask

  task automatic pause_until_empty();
    in_bus.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // A byte may still be in the pipe without a cut to show for it.
  task automatic drain();
    pause_until_empty();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_regs(logic [63:0] m, logic [63:0] lo, logic [63:0] hi, bit poke_unused);
    logic [ghc_pkg::CFG_IDX_BITS-1:0]  idx [4];
    logic [ghc_pkg::CFG_DATA_BITS-1:0] val [4];
    int                                n;
    int                                k;
    n = 0;
    if (poke_unused) begin
      idx[n] = REG_UNUSED;
      val[n] = {$urandom, $urandom};
      n++;
    end
    idx[n] = ghc_pkg::REG_BOUNDARY_MASK;
    val[n] = m;
    n++;
    idx[n] = ghc_pkg::REG_MIN_CHUNK;
    val[n] = lo;
    n++;
    idx[n] = ghc_pkg::REG_MAX_CHUNK;
    val[n] = hi;
    n++;
    for (k = 0; k < n; k++) begin
      cfg_bus.valid <= 1'b1;
      cfg_bus.index <= idx[k];
      cfg_bus.data  <= val[k];
      do @(posedge clk); while (!cfg_bus.ready);
      sb.write_reg(idx[k], val[k]);
    end
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic random_stream(int n, int eod_div);
    int i;
    for (i = 0; i < n; i++) begin
      send_byte(8'($urandom_range(0, 255)), $urandom_range(0, eod_div - 1) == 0);
      if ($urandom_range(0, 149) == 0) begin
        pause_until_empty();
      end
    end
  endtask

  // Result side: random back-pressure, every transfer checked in order.
  initial begin
    int stall;
    stall = 0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_bus.valid && out_bus.ready) begin
        sb.check_cut(out_bus.boundary_offset, out_bus.chunk_length, out_bus.cut_reason);
      end
      if (!rst_n) begin
        out_bus.ready <= 1'b0;
      end else if (stall > 0) begin
        out_bus.ready <= 1'b0;
        stall--;
      end else begin
        out_bus.ready <= 1'b1;
        stall = idle_len(out_calm);
      end
    end
  end

  initial begin
    int sent;
    int n;
    int i;
    sb = new();
    in_calm  = 1'b0;
    out_calm = 1'b0;
    rst_n              <= 1'b0;
    in_bus.valid       <= 1'b0;
    in_bus.data_byte   <= '0;
    in_bus.end_of_data <= 1'b0;
    cfg_bus.valid      <= 1'b0;
    cfg_bus.index      <= '0;
    cfg_bus.data       <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Register defaults: short streams end only on their last byte.
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h5A, 1'b1);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h3C, 1'b1);
    drain();

    // Zero maximum forces a cut on every byte and outranks end of data.
    set_regs('1, 64'd0, 64'd0, 1'b1);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0);
    drain();

    // Empty mask: a content match outranks both other reasons.
    set_regs('0, 64'd1, 64'd1, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h01, 1'b1);
    drain();

    // Zero minimum checks content from the first byte.
    set_regs('0, 64'd0, 64'd65536, 1'b0);
    send_byte(8'h7E, 1'b0);
    drain();

    // Minimum above maximum: only forced cuts remain.
    set_regs('0, 64'(ghc_pkg::CHUNK_LIMIT), 64'd3, 1'b0);
    for (i = 0; i < 7; i++) begin
      send_byte(8'($urandom_range(0, 255)), i == 6);
    end
    drain();

    set_regs(64'h3, 64'd2, 64'(ghc_pkg::CHUNK_LIMIT), 1'b0);
    for (i = 0; i < 6; i++) begin
      send_byte(8'($urandom_range(0, 255)), i == 5);
    end
    drain();

    sent = 0;
    while (sent < RANDOM_BYTES) begin
      n        = $urandom_range(60, 200);
      in_calm  = ($urandom_range(0, 3) == 0);
      out_calm = ($urandom_range(0, 3) == 0);
      set_regs(pick_mask(), pick_len(1'b0), pick_len(1'b1), $urandom_range(0, 2) == 0);
      random_stream(n, $urandom_range(8, 40));
      sent += n;
      drain();
    end

    // Maximum beyond the hardware limit: a short stream still ends on its last byte.
    in_calm  = 1'b1;
    out_calm = 1'b1;
    set_regs('1, 64'h1F_FFFF, 64'h1F_FFFF, 1'b0);
    for (i = 0; i < 5; i++) begin
      send_byte(8'($urandom_range(0, 255)), i == 4);
    end
    drain();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
